[rtl/flow_statistics_table_defines.svh]
// ----------------------------------------------------------------------------
// flow statistics table assertion macros
// shared concurrent assertion forms, clocked on clk and quiet in reset
// ----------------------------------------------------------------------------
`ifndef FLOW_STATISTICS_TABLE_DEFINES_SVH
`define FLOW_STATISTICS_TABLE_DEFINES_SVH

// condition implies consequence in the same cycle
`define FST_ASSERT_SAME(lbl, cond, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) else $error(msg);

// condition implies consequence in the next cycle
`define FST_ASSERT_NEXT(lbl, cond, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) else $error(msg);

`endif

[rtl/fst_pkg.sv]
// ----------------------------------------------------------------------------
// fst_pkg
// types, codes and sizes shared by the flow statistics table modules
// ----------------------------------------------------------------------------
package fst_pkg;

  // table geometry
  localparam int TABLE_ENTRIES = 1024;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int CNT_W         = IDX_W + 1;

  // rate scaling: gain * 1000 is at most 74 bits
  localparam int DVD_W         = 74;
  localparam int STEP_W        = $clog2(DVD_W + 1);

  // register map
  localparam logic        REG_RATE_WINDOW   = 1'b0;
  localparam logic [15:0] RATE_WINDOW_RESET = 16'd1000;

  // request kinds
  localparam logic [1:0] KIND_UPDATE = 2'd0;
  localparam logic [1:0] KIND_LOOKUP = 2'd1;
  localparam logic [1:0] KIND_PURGE  = 2'd2;
  localparam logic [1:0] KIND_CLEAR  = 2'd3;

  // result status codes
  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_UPDATED   = 3'd1;
  localparam logic [2:0] ST_FOUND     = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;
  localparam logic [2:0] ST_PURGED    = 3'd5;

  // one stored flow; index 0 packets, 1 bytes, 2 payload bytes
  typedef struct packed {
    logic             vld;
    logic [127:0]     key;
    logic [2:0][63:0] tot;
    logic [2:0][63:0] gain;
    logic [2:0][31:0] rate;
    logic [31:0]      tm;
  } fst_rec_t;

  // divider status toward the controller
  typedef struct packed {
    logic busy;
    logic done;
  } fst_div_stat_t;

  // gain * 1000 by shifts: 1024 - 16 - 8
  function automatic logic [DVD_W-1:0] times_ms_per_sec(input logic [63:0] g);
    logic [DVD_W-1:0] w;
    begin
      w = {{(DVD_W-64){1'b0}}, g};
      return (w << 10) - (w << 4) - (w << 3);
    end
  endfunction

endpackage

[rtl/fst_table_mem.sv]
// ----------------------------------------------------------------------------
// fst_table_mem
// flow record store, one write port and one read port, registered read
// ----------------------------------------------------------------------------
module fst_table_mem
  import fst_pkg::*;
(
  input  logic             clk,
  input  logic             we,
  input  logic [IDX_W-1:0] waddr,
  input  fst_rec_t         wdata,
  input  logic [IDX_W-1:0] raddr,
  output fst_rec_t         rdata
);

  fst_rec_t mem [TABLE_ENTRIES];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[rtl/fst_divider.sv]
// ----------------------------------------------------------------------------
// fst_divider
// restoring divider, one quotient bit a cycle, quotient saturated to 32 bits
// ----------------------------------------------------------------------------
module fst_divider
  import fst_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [31:0]      divisor,
  output fst_div_stat_t    stat,
  output logic [31:0]      quotient
);

  logic              busy;
  logic              done;
  logic [STEP_W-1:0] step;
  logic [DVD_W-1:0]  dvd;
  logic [31:0]       dsr;
  logic [31:0]       rem;
  logic [31:0]       q;
  logic              ovf;
  logic [32:0]       rem_sh;
  logic              ge;
  logic [31:0]       rem_next;

  // one trial subtraction
  always_comb begin
    rem_sh   = {rem, dvd[DVD_W-1]};
    ge       = rem_sh >= {1'b0, dsr};
    rem_next = ge ? 32'(rem_sh - {1'b0, dsr}) : rem_sh[31:0];
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == STEP_W'(DVD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dsr <= divisor;
      rem <= '0;
      q   <= '0;
      ovf <= 1'b0;
    end else if (busy) begin
      dvd <= dvd << 1;
      rem <= rem_next;
      q   <= {q[30:0], ge};
      ovf <= ovf | q[31];
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quotient  = ovf ? '1 : q;

endmodule

[rtl/flow_statistics_table.sv]
// ----------------------------------------------------------------------------
// flow_statistics_table
// keyed flow accounting table with lookup, purge and clear
// ----------------------------------------------------------------------------
// Operation: after reset a clearing pass writes all 1024 entries, one a cycle,
// and no beat is taken in that time. Each request then walks the record
// memory one entry a cycle through its single read port: an update or lookup
// stops at the first key match (a miss scans the whole table), a purge or
// clear scans the whole table. An update that reports no rates and whose
// window has run out adds three divisions in the shared bit-serial divider.
// The result sits in an output register; the next beat is taken once the
// result is loaded there.
// ----------------------------------------------------------------------------
`include "flow_statistics_table_defines.svh"

module flow_statistics_table
  import fst_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  // apb configuration
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  // request channel
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [1:0]   kind,
  input  logic [63:0]  key_high,
  input  logic [63:0]  key_low,
  input  logic [31:0]  packet_count,
  input  logic [31:0]  packet_bytes,
  input  logic [31:0]  payload_bytes,
  input  logic [31:0]  packet_rate,
  input  logic [31:0]  byte_rate,
  input  logic [31:0]  payload_rate,
  input  logic [31:0]  time_ms,
  // result channel
  output logic         out_valid,
  input  logic         out_ready,
  output logic [2:0]   status,
  output logic [63:0]  total_packets,
  output logic [63:0]  total_bytes,
  output logic [63:0]  total_payload,
  output logic [31:0]  current_packet_rate,
  output logic [31:0]  current_byte_rate,
  output logic [31:0]  current_payload_rate,
  output logic [31:0]  last_time_ms,
  output logic [10:0]  removed_count
);

  typedef enum logic [8:0] {
    S_INIT  = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_SRCH  = 9'b000000100,
    S_PURGE = 9'b000001000,
    S_UPD   = 9'b000010000,
    S_DLD   = 9'b000100000,
    S_DWT   = 9'b001000000,
    S_WB    = 9'b010000000,
    S_FIN   = 9'b100000000
  } state_t;

  localparam logic [CNT_W-1:0] N_ENTRIES  = CNT_W'(TABLE_ENTRIES);
  localparam logic [IDX_W-1:0] LAST_ENTRY = IDX_W'(TABLE_ENTRIES - 1);

  state_t            state;
  logic [15:0]       rate_window;
  logic [15:0]       win;

  // latched request
  logic [1:0]        kind_q;
  logic [127:0]      key_q;
  logic [2:0][31:0]  cnt_q;
  logic [2:0][31:0]  rate_q;
  logic [31:0]       now_q;

  // walk and working record
  logic [CNT_W-1:0]  ptr;
  logic              pend;
  logic [IDX_W-1:0]  pend_addr;
  logic              free_found;
  logic [IDX_W-1:0]  free_addr;
  logic [IDX_W-1:0]  wb_addr;
  fst_rec_t          rec;
  logic [2:0]        st_q;
  logic [10:0]       removed;
  logic [1:0]        lane;
  logic [31:0]       diff_q;
  logic [31:0]       diff;
  logic              window_due;

  // memory ports
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  fst_rec_t          mem_wdata;
  fst_rec_t          rdata;
  logic              purge_hit;
  logic              walk_end;

  // divider
  fst_div_stat_t     div_stat;
  logic [31:0]       div_quot;
  logic              rec_out;

  // configuration register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_RATE_WINDOW) ? {16'b0, rate_window} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      rate_window <= RATE_WINDOW_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_RATE_WINDOW) begin
      rate_window <= pwdata[15:0];
    end
  end

  assign win        = (rate_window == '0) ? 16'd1 : rate_window;
  assign diff       = now_q - rec.tm;
  assign window_due = !diff[31] && (diff >= {16'b0, win});

  assign in_ready = (state == S_IDLE);
  assign walk_end = !pend && (ptr == N_ENTRIES);
  assign purge_hit = pend && rdata.vld && (kind_q == KIND_CLEAR || rdata.tm < now_q);

  // record memory
  fst_table_mem u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (ptr[IDX_W-1:0]),
    .rdata (rdata)
  );

  // write port select
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = wb_addr;
    mem_wdata = rec;
    unique case (state)
      S_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = ptr[IDX_W-1:0];
        mem_wdata = '0;
      end
      S_PURGE: begin
        mem_we        = purge_hit;
        mem_waddr     = pend_addr;
        mem_wdata     = rdata;
        mem_wdata.vld = 1'b0;
      end
      S_WB: begin
        mem_we = 1'b1;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // shared rate divider
  fst_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (state == S_DLD),
    .dividend (times_ms_per_sec(rec.gain[lane])),
    .divisor  (diff_q),
    .stat     (div_stat),
    .quotient (div_quot)
  );

  // controller
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      ptr       <= '0;
      pend      <= 1'b0;
    end else begin
      unique case (state)
        S_INIT: begin
          if (ptr[IDX_W-1:0] == LAST_ENTRY) begin
            ptr   <= '0;
            state <= S_IDLE;
          end else begin
            ptr <= ptr + 1'b1;
          end
        end
        S_IDLE: begin
          ptr        <= '0;
          pend       <= 1'b0;
          free_found <= 1'b0;
          removed    <= '0;
          if (in_valid) begin
            kind_q <= kind;
            key_q  <= {key_high, key_low};
            cnt_q  <= {payload_bytes, packet_bytes, packet_count};
            rate_q <= {payload_rate, byte_rate, packet_rate};
            now_q  <= time_ms;
            state  <= (kind == KIND_PURGE || kind == KIND_CLEAR) ? S_PURGE : S_SRCH;
          end
        end
        S_SRCH: begin
          if (ptr != N_ENTRIES) begin
            ptr <= ptr + 1'b1;
          end
          pend      <= (ptr != N_ENTRIES);
          pend_addr <= ptr[IDX_W-1:0];
          if (pend && !rdata.vld && !free_found) begin
            free_found <= 1'b1;
            free_addr  <= pend_addr;
          end
          priority if (pend && rdata.vld && rdata.key == key_q) begin
            rec     <= rdata;
            wb_addr <= pend_addr;
            if (kind_q == KIND_LOOKUP) begin
              st_q  <= ST_FOUND;
              state <= S_FIN;
            end else begin
              state <= S_UPD;
            end
          end else if (walk_end) begin
            if (kind_q == KIND_LOOKUP) begin
              st_q  <= ST_NOT_FOUND;
              state <= S_FIN;
            end else if (free_found) begin
              rec.vld  <= 1'b1;
              rec.key  <= key_q;
              for (int j = 0; j < 3; j++) begin
                rec.tot[j]  <= {32'b0, cnt_q[j]};
                rec.gain[j] <= {32'b0, cnt_q[j]};
              end
              rec.rate <= rate_q;
              rec.tm   <= now_q;
              wb_addr  <= free_addr;
              st_q     <= ST_INSERTED;
              state    <= S_WB;
            end else begin
              st_q  <= ST_FULL;
              state <= S_FIN;
            end
          end else begin
            state <= S_SRCH;
          end
        end
        S_PURGE: begin
          if (ptr != N_ENTRIES) begin
            ptr <= ptr + 1'b1;
          end
          pend      <= (ptr != N_ENTRIES);
          pend_addr <= ptr[IDX_W-1:0];
          if (purge_hit && removed != '1) begin
            removed <= removed + 1'b1;
          end
          if (walk_end) begin
            st_q  <= ST_PURGED;
            state <= S_FIN;
          end
        end
        S_UPD: begin
          // add counts, then pick reported rates, window scaling or neither
          for (int j = 0; j < 3; j++) begin
            rec.tot[j]  <= rec.tot[j] + {32'b0, cnt_q[j]};
            rec.gain[j] <= rec.gain[j] + {32'b0, cnt_q[j]};
          end
          st_q   <= ST_UPDATED;
          diff_q <= diff;
          lane   <= '0;
          priority if (|rate_q) begin
            rec.rate <= rate_q;
            rec.tm   <= now_q;
            state    <= S_WB;
          end else if (window_due) begin
            rec.tm <= now_q;
            state  <= S_DLD;
          end else begin
            state <= S_WB;
          end
        end
        S_DLD: begin
          state <= S_DWT;
        end
        S_DWT: begin
          if (div_stat.done) begin
            if (div_quot != '0) begin
              rec.rate[lane] <= div_quot;
            end
            rec.gain[lane] <= '0;
            lane  <= lane + 1'b1;
            state <= (lane == 2'd2) ? S_WB : S_DLD;
          end
        end
        S_WB: begin
          state <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid || out_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_FIN && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // result register
  assign rec_out = (st_q == ST_INSERTED) || (st_q == ST_UPDATED) || (st_q == ST_FOUND);

  always_ff @(posedge clk) begin
    if (state == S_FIN && (!out_valid || out_ready)) begin
      status               <= st_q;
      total_packets        <= rec_out ? rec.tot[0] : '0;
      total_bytes          <= rec_out ? rec.tot[1] : '0;
      total_payload        <= rec_out ? rec.tot[2] : '0;
      current_packet_rate  <= rec_out ? rec.rate[0] : '0;
      current_byte_rate    <= rec_out ? rec.rate[1] : '0;
      current_payload_rate <= rec_out ? rec.rate[2] : '0;
      last_time_ms         <= rec_out ? rec.tm : '0;
      removed_count        <= (st_q == ST_PURGED) ? removed : '0;
    end
  end

  // checks
  `FST_ASSERT_SAME(a_div_done_wait, div_stat.done, state == S_DWT, "divider result outside wait")
  `FST_ASSERT_SAME(a_no_write_idle, mem_we, state != S_IDLE && state != S_FIN, "memory write while idle")
  `FST_ASSERT_NEXT(a_one_beat, in_valid && in_ready, !in_ready, "second beat taken during work")
  `FST_ASSERT_SAME(a_div_idle_busy, state == S_DLD, !div_stat.busy, "divider restarted while busy")

endmodule

[test/flow_statistics_table_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flow_statistics_table_tb
// Self-checking bench for the flow statistics table. A behavioral copy of the
// table predicts every result. Directed tests cover the corner cases, a fill
// test drives the table to full, and random phases run under varied idling
// and rate windows.
// ----------------------------------------------------------------------------
module flow_statistics_table_tb;
  import fst_pkg::*;

  localparam int CYCLE_LIMIT = 20_000_000;
  localparam int POOL_SIZE   = 16;

  typedef struct {
    logic [1:0]       kind;
    logic [127:0]     key;
    logic [2:0][31:0] cnt;
    logic [2:0][31:0] rt;
    logic [31:0]      tm;
  } flow_req_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [2:0][63:0] tot;
    logic [2:0][31:0] rate;
    logic [31:0]      tm;
    logic [10:0]      removed;
  } flow_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] kind = '0;
  logic [63:0] key_high = '0, key_low = '0;
  logic [31:0] packet_count = '0, packet_bytes = '0, payload_bytes = '0;
  logic [31:0] packet_rate = '0, byte_rate = '0, payload_rate = '0, time_ms = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [2:0] status;
  logic [63:0] total_packets, total_bytes, total_payload;
  logic [31:0] current_packet_rate, current_byte_rate, current_payload_rate;
  logic [31:0] last_time_ms;
  logic [10:0] removed_count;

  flow_statistics_table dut (.*);

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow table
  logic [15:0]      shadow_window;
  logic             tbl_valid [TABLE_ENTRIES];
  logic [127:0]     tbl_key   [TABLE_ENTRIES];
  logic [2:0][63:0] tbl_tot   [TABLE_ENTRIES];
  logic [2:0][63:0] tbl_gain  [TABLE_ENTRIES];
  logic [2:0][31:0] tbl_rate  [TABLE_ENTRIES];
  logic [31:0]      tbl_time  [TABLE_ENTRIES];

  flow_res_t expected_results [$];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatches = 0;
  int cycles = 0;
  logic [31:0] now_ms = '0;
  logic [127:0] key_pool [POOL_SIZE];

  // gain scaled to per-second rate, saturating
  function automatic logic [31:0] per_second(logic [63:0] g, logic [31:0] e);
    logic [95:0] q;
    q = ({32'b0, g} * 96'd1000) / {64'b0, e};
    return (q > 96'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
  endfunction

  function automatic flow_res_t record_of(int s, logic [2:0] st);
    flow_res_t x;
    x = '0;
    x.status = st;
    x.tot = tbl_tot[s];
    x.rate = tbl_rate[s];
    x.tm = tbl_time[s];
    return x;
  endfunction

  // advance the shadow table by one request
  task automatic predict_flow(input flow_req_t r, output flow_res_t x);
    int hit, freeslot, removed;
    logic [31:0] diff, win, nr;
    x = '0;
    hit = -1;
    freeslot = -1;
    removed = 0;
    if (r.kind == KIND_PURGE || r.kind == KIND_CLEAR) begin
      for (int s = 0; s < TABLE_ENTRIES; s++)
        if (tbl_valid[s] && (r.kind == KIND_CLEAR || tbl_time[s] < r.tm)) begin
          tbl_valid[s] = 1'b0;
          removed++;
        end
      x.status = ST_PURGED;
      x.removed = (removed > 2047) ? 11'd2047 : removed[10:0];
      return;
    end
    for (int s = 0; s < TABLE_ENTRIES; s++) begin
      if (tbl_valid[s]) begin
        if (hit < 0 && tbl_key[s] == r.key) hit = s;
      end else if (freeslot < 0) begin
        freeslot = s;
      end
    end
    if (r.kind == KIND_LOOKUP) begin
      if (hit < 0) x.status = ST_NOT_FOUND;
      else x = record_of(hit, ST_FOUND);
      return;
    end
    if (hit < 0) begin
      if (freeslot < 0) begin
        x.status = ST_FULL;
        return;
      end
      tbl_valid[freeslot] = 1'b1;
      tbl_key[freeslot] = r.key;
      for (int j = 0; j < 3; j++) begin
        tbl_tot[freeslot][j] = {32'b0, r.cnt[j]};
        tbl_gain[freeslot][j] = {32'b0, r.cnt[j]};
        tbl_rate[freeslot][j] = r.rt[j];
      end
      tbl_time[freeslot] = r.tm;
      x = record_of(freeslot, ST_INSERTED);
      return;
    end
    for (int j = 0; j < 3; j++) begin
      tbl_tot[hit][j] += {32'b0, r.cnt[j]};
      tbl_gain[hit][j] += {32'b0, r.cnt[j]};
    end
    if (r.rt != '0) begin
      // reported rates win, gains are kept
      tbl_time[hit] = r.tm;
      tbl_rate[hit] = r.rt;
    end else begin
      diff = r.tm - tbl_time[hit];
      win = (shadow_window == 16'd0) ? 32'd1 : {16'b0, shadow_window};
      if (!diff[31] && diff >= win) begin
        tbl_time[hit] = r.tm;
        for (int j = 0; j < 3; j++) begin
          nr = per_second(tbl_gain[hit][j], diff);
          if (nr != '0) tbl_rate[hit][j] = nr;
          tbl_gain[hit][j] = '0;
        end
      end
    end
    x = record_of(hit, ST_UPDATED);
  endtask

  // one request beat; valid stays high on return, drain or an idle gap in the next call lowers it
  task automatic send_request(input flow_req_t r);
    flow_res_t x;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    predict_flow(r, x);
    expected_results.push_back(x);
    in_valid <= 1'b1;
    kind <= r.kind;
    {key_high, key_low} <= r.key;
    packet_count <= r.cnt[0];
    packet_bytes <= r.cnt[1];
    payload_bytes <= r.cnt[2];
    packet_rate <= r.rt[0];
    byte_rate <= r.rt[1];
    payload_rate <= r.rt[2];
    time_ms <= r.tm;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // apb write, block idle
  task automatic write_window(input logic [15:0] w);
    drain();
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= {REG_RATE_WINDOW, 2'b00};
    pwdata <= {16'b0, w};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    shadow_window = w;
  endtask

  function automatic flow_req_t make_req(logic [1:0] k, logic [127:0] key,
                                         logic [31:0] c, logic [31:0] rt,
                                         logic [31:0] t);
    flow_req_t r;
    r.kind = k;
    r.key = key;
    r.cnt = {c, c, c};
    r.rt = {rt, rt, rt};
    r.tm = t;
    return r;
  endfunction

  function automatic logic [31:0] rand32();
    return $urandom();
  endfunction

  function automatic logic [127:0] rand_key();
    return {rand32(), rand32(), rand32(), rand32()};
  endfunction

  // receiver stalls
  always @(posedge clk)
    out_ready <= ($urandom_range(99) >= recv_stall_pct);

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch %s: expected %h actual %h", name, exp_v, act_v);
    end
  endtask

  // result checker
  always @(posedge clk) begin
    flow_res_t e;
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: result beat with none expected");
      end else begin
        e = expected_results.pop_front();
        check_field("status", e.status, status);
        check_field("total_packets", e.tot[0], total_packets);
        check_field("total_bytes", e.tot[1], total_bytes);
        check_field("total_payload", e.tot[2], total_payload);
        check_field("current_packet_rate", e.rate[0], current_packet_rate);
        check_field("current_byte_rate", e.rate[1], current_byte_rate);
        check_field("current_payload_rate", e.rate[2], current_payload_rate);
        check_field("last_time_ms", e.tm, last_time_ms);
        check_field("removed_count", e.removed, removed_count);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // corner cases of counts, rates, time and window
  task automatic test_directed;
    logic [127:0] ka, kb;
    ka = '1;
    kb = {64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210};
    write_window(16'd1);
    send_request(make_req(KIND_UPDATE, ka, '1, '0, 32'd0));
    send_request(make_req(KIND_UPDATE, ka, '1, '0, 32'd0));
    // saturating rate over one ms
    send_request(make_req(KIND_UPDATE, ka, '1, '0, 32'd1));
    send_request(make_req(KIND_UPDATE, ka, 32'd5, '1, 32'd7));
    send_request(make_req(KIND_LOOKUP, ka, '0, '0, '0));
    send_request(make_req(KIND_LOOKUP, '0, '0, '0, '0));
    // time running backward
    send_request(make_req(KIND_UPDATE, ka, 32'd3, '0, 32'd2));
    // zero gain leaves rates as they are
    send_request(make_req(KIND_UPDATE, '0, '0, '0, 32'd100));
    send_request(make_req(KIND_UPDATE, '0, '0, '0, 32'd5000));
    send_request(make_req(KIND_UPDATE, kb, 32'd1, '0, '1));
    send_request(make_req(KIND_UPDATE, {kb[127:64], ~kb[63:0]}, 32'd9, 32'd3, 32'd50));
    send_request(make_req(KIND_UPDATE, kb, 32'd1000, '0, 32'd10));
    send_request(make_req(KIND_PURGE, '0, '0, '0, 32'd0));
    send_request(make_req(KIND_PURGE, '0, '0, '0, 32'd60));
    send_request(make_req(KIND_LOOKUP, kb, '0, '0, '0));
    send_request(make_req(KIND_PURGE, '0, '0, '0, '1));
    send_request(make_req(KIND_CLEAR, '0, '0, '0, '0));
    write_window(16'hFFFF);
    send_request(make_req(KIND_UPDATE, kb, 32'd77, '0, 32'd0));
    send_request(make_req(KIND_UPDATE, kb, 32'd77, '0, 32'd65534));
    send_request(make_req(KIND_UPDATE, kb, 32'd77, '0, 32'd65535));
    write_window(16'd0);
    send_request(make_req(KIND_UPDATE, kb, 32'd4, '0, 32'd65536));
    send_request(make_req(KIND_CLEAR, '0, '0, '0, '1));
    drain();
  endtask

  // fill every slot, then hit the full table
  task automatic test_table_full;
    flow_req_t r;
    logic [127:0] first_key;
    write_window(16'd1000);
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      r = make_req(KIND_UPDATE, rand_key(), rand32(), '0, i * 10);
      r.cnt = {rand32(), rand32(), rand32()};
      if (i == 0) first_key = r.key;
      send_request(r);
    end
    send_request(make_req(KIND_UPDATE, rand_key(), 32'd1, '0, 32'd20000));
    send_request(make_req(KIND_UPDATE, first_key, 32'd1, '0, 32'd20000));
    send_request(make_req(KIND_LOOKUP, first_key, '0, '0, '0));
    send_request(make_req(KIND_PURGE, '0, '0, '0, 32'd5000));
    send_request(make_req(KIND_CLEAR, '0, '0, '0, '0));
    drain();
  endtask

  // random traffic over a small key pool
  task automatic test_random(input int items, input int sidle, input int rstall,
                             input logic [15:0] win);
    flow_req_t r;
    int pick;
    write_window(win);
    send_idle_pct = sidle;
    recv_stall_pct = rstall;
    for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = rand_key();
    key_pool[1][127:64] = key_pool[0][127:64];
    key_pool[2][63:0] = key_pool[0][63:0];
    for (int i = 0; i < items; i++) begin
      pick = $urandom_range(99);
      if ($urandom_range(9) == 0) now_ms = now_ms - $urandom_range(2000);
      else now_ms = now_ms + $urandom_range(3 * win + 2);
      r = make_req(KIND_UPDATE, key_pool[$urandom_range(POOL_SIZE - 1)], '0, '0, now_ms);
      case ($urandom_range(3))
        0: r.cnt = {rand32(), rand32(), rand32()};
        default: r.cnt = {32'($urandom_range(5000)), 32'($urandom_range(900000)),
                          32'($urandom_range(800000))};
      endcase
      if ($urandom_range(3) == 0) r.rt = {rand32(), rand32(), rand32()};
      if (pick < 5) r.key = rand_key();
      if (pick >= 65 && pick < 85) r.kind = KIND_LOOKUP;
      else if (pick >= 85 && pick < 96) begin
        r.kind = KIND_PURGE;
        r.tm = now_ms - $urandom_range(4 * win + 2);
      end else if (pick >= 96) begin
        r.kind = KIND_CLEAR;
        r.tm = rand32();
      end
      send_request(r);
    end
    drain();
  endtask

  initial begin
    shadow_window = RATE_WINDOW_RESET;
    for (int s = 0; s < TABLE_ENTRIES; s++) tbl_valid[s] = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 32;
    recv_stall_pct = 50;
    test_directed();
    test_table_full();
    test_random(40, 32, 50, 16'($urandom_range(1, 3000)));
    test_random(40, 50, 32, 16'd1);
    test_random(30, 0, 0, 16'hFFFF);
    repeat (50) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
